>>> hw/rtl/rv64_icd_pkg.sv
// Shared types and encodings for the RV64 instruction control decoder.
package rv64_icd_pkg;

    localparam int unsigned InstrWidth = 32;
    localparam int unsigned AluOpWidth = 7;

    typedef logic [6:0] opcode_t;
    typedef logic [6:0] funct7_t;

    localparam opcode_t OPC_OP        = 7'b0110011;
    localparam opcode_t OPC_LOAD      = 7'b0000011;
    localparam opcode_t OPC_STORE     = 7'b0100011;
    localparam opcode_t OPC_BRANCH    = 7'b1100011;
    localparam opcode_t OPC_OP_IMM    = 7'b0010011;
    localparam opcode_t OPC_OP_FP     = 7'b1010011;
    localparam opcode_t OPC_OP_IMM_32 = 7'b0011011;
    localparam opcode_t OPC_OP_32     = 7'b0111011;
    localparam opcode_t OPC_JAL       = 7'b1101111;
    localparam opcode_t OPC_JALR      = 7'b1100111;
    localparam opcode_t OPC_LUI       = 7'b0110111;
    localparam opcode_t OPC_AUIPC     = 7'b0010111;
    localparam opcode_t OPC_LOAD_FP   = 7'b0000111;
    localparam opcode_t OPC_STORE_FP  = 7'b0100111;
    localparam opcode_t OPC_MADD      = 7'b1000011;
    localparam opcode_t OPC_ALT_RTYPE = 7'b0000001;

    localparam funct7_t F7_BASE   = 7'b0000000;
    localparam funct7_t F7_ALT    = 7'b0100000;
    localparam funct7_t F7_MULDIV = 7'b0000001;

    localparam funct7_t F7_FADD_S   = 7'h00;
    localparam funct7_t F7_FADD_D   = 7'h01;
    localparam funct7_t F7_FSUB_S   = 7'h04;
    localparam funct7_t F7_FSUB_D   = 7'h05;
    localparam funct7_t F7_FMUL_S   = 7'h08;
    localparam funct7_t F7_FMUL_D   = 7'h09;
    localparam funct7_t F7_FDIV_S   = 7'h0C;
    localparam funct7_t F7_FDIV_D   = 7'h0D;
    localparam funct7_t F7_FSQRT_S  = 7'h2C;
    localparam funct7_t F7_FSQRT_D  = 7'h2D;
    localparam funct7_t F7_FCVT_X_S = 7'h60;
    localparam funct7_t F7_FCVT_X_D = 7'h61;
    localparam funct7_t F7_FCVT_S_X = 7'h68;
    localparam funct7_t F7_FCVT_D_X = 7'h69;
    localparam funct7_t F7_FSGNJ_S  = 7'h10;
    localparam funct7_t F7_FSGNJ_D  = 7'h11;
    localparam funct7_t F7_FMINMAX_S = 7'h14;
    localparam funct7_t F7_FMINMAX_D = 7'h15;
    localparam funct7_t F7_FCMP_S   = 7'h50;
    localparam funct7_t F7_FCMP_D   = 7'h51;
    localparam funct7_t F7_FMV_W_X  = 7'h78;
    localparam funct7_t F7_FMV_D_X  = 7'h79;
    localparam funct7_t F7_FMV_X_S  = 7'h70;
    localparam funct7_t F7_FMV_X_D  = 7'h71;

    typedef enum logic [AluOpWidth-1:0] {
        ALU_NONE = 7'd0,
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_SLL, ALU_MULH, ALU_SLT, ALU_MULHSU,
        ALU_SLTU, ALU_MULHU, ALU_XOR, ALU_DIV, ALU_SRL, ALU_SRA, ALU_DIVU, ALU_OR,
        ALU_REM, ALU_AND, ALU_REMU, ALU_ADDW, ALU_SLLW, ALU_SRLW, ALU_SRAW, ALU_SUBW,
        ALU_MULW, ALU_DIVW, ALU_DIVUW, ALU_REMW, ALU_REMUW, ALU_FMADD_S,
        ALU_FADD_S, ALU_FADD_D, ALU_FSUB_S, ALU_FSUB_D, ALU_FMUL_S, ALU_FMUL_D,
        ALU_FDIV_S, ALU_FDIV_D, ALU_FSQRT_S, ALU_FSQRT_D,
        ALU_FCVT_W_S, ALU_FCVT_WU_S, ALU_FCVT_L_S, ALU_FCVT_LU_S,
        ALU_FCVT_W_D, ALU_FCVT_WU_D, ALU_FCVT_L_D, ALU_FCVT_LU_D,
        ALU_FCVT_S_W, ALU_FCVT_S_WU, ALU_FCVT_S_L, ALU_FCVT_S_LU,
        ALU_FCVT_D_W, ALU_FCVT_D_WU, ALU_FCVT_D_L, ALU_FCVT_D_LU,
        ALU_FSGNJ_S, ALU_FSGNJN_S, ALU_FSGNJX_S, ALU_FSGNJ_D, ALU_FSGNJN_D, ALU_FSGNJX_D,
        ALU_FMIN_S, ALU_FMAX_S, ALU_FMIN_D, ALU_FMAX_D,
        ALU_FEQ_S, ALU_FLT_S, ALU_FLE_S, ALU_FEQ_D, ALU_FLT_D, ALU_FLE_D,
        ALU_FMV_W_X, ALU_FMV_D_X, ALU_FMV_X_W, ALU_FCLASS_S, ALU_FMV_X_D, ALU_FCLASS_D,
        ALU_FMADD_D, ALU_FMSUB_S, ALU_FMSUB_D, ALU_FNMADD_S, ALU_FNMADD_D,
        ALU_FNMSUB_S, ALU_FNMSUB_D
    } alu_op_t;

    typedef struct packed {
        logic reg_write;
        logic alu_src_imm;
        logic mem_to_reg;
        logic mem_read;
        logic mem_write;
        logic branch;
        logic alu_use;
    } ctrl_flags_t;

    typedef struct packed {
        alu_op_t     op;
        ctrl_flags_t flags;
    } dec_result_t;

endpackage

>>> hw/rtl/rv64_icd_decode.sv
// Combinational decode of one instruction word into control flags and an ALU operation.
module rv64_icd_decode
    import rv64_icd_pkg::*;
(
    input  logic [InstrWidth-1:0] instr,
    output dec_result_t           result
);

    opcode_t     opc;
    logic [2:0]  f3;
    funct7_t     f7;
    logic [4:0]  f5;
    alu_op_t     rr_op;
    alu_op_t     m_op;
    alu_op_t     fp_op;
    alu_op_t     op;
    ctrl_flags_t flags;

    assign opc = instr[6:0];
    assign f3  = instr[14:12];
    assign f7  = instr[31:25];
    assign f5  = instr[24:20];

    always_comb
    begin
        unique case (f3)
            3'd0: rr_op = ALU_ADD;
            3'd1: rr_op = ALU_SLL;
            3'd2: rr_op = ALU_SLT;
            3'd3: rr_op = ALU_SLTU;
            3'd4: rr_op = ALU_XOR;
            3'd5: rr_op = ALU_SRL;
            3'd6: rr_op = ALU_OR;
            default: rr_op = ALU_AND;
        endcase
        unique case (f3)
            3'd0: m_op = ALU_MUL;
            3'd1: m_op = ALU_MULH;
            3'd2: m_op = ALU_MULHSU;
            3'd3: m_op = ALU_MULHU;
            3'd4: m_op = ALU_DIV;
            3'd5: m_op = ALU_DIVU;
            3'd6: m_op = ALU_REM;
            default: m_op = ALU_REMU;
        endcase
    end

    // The fused encodings under the FP opcode need funct2 equal to funct7[1:0], which is
    // always three for those funct7 values, so they fall through to no operation.
    always_comb
    begin
        fp_op = ALU_NONE;
        unique case (f7)
            F7_FADD_S:  fp_op = ALU_FADD_S;
            F7_FADD_D:  fp_op = ALU_FADD_D;
            F7_FSUB_S:  fp_op = ALU_FSUB_S;
            F7_FSUB_D:  fp_op = ALU_FSUB_D;
            F7_FMUL_S:  fp_op = ALU_FMUL_S;
            F7_FMUL_D:  fp_op = ALU_FMUL_D;
            F7_FDIV_S:  fp_op = ALU_FDIV_S;
            F7_FDIV_D:  fp_op = ALU_FDIV_D;
            F7_FSQRT_S: fp_op = ALU_FSQRT_S;
            F7_FSQRT_D: fp_op = ALU_FSQRT_D;
            F7_FCVT_X_S:
            begin
                unique case (f5)
                    5'd0: fp_op = ALU_FCVT_W_S;
                    5'd1: fp_op = ALU_FCVT_WU_S;
                    5'd2: fp_op = ALU_FCVT_L_S;
                    5'd3: fp_op = ALU_FCVT_LU_S;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FCVT_X_D:
            begin
                unique case (f5)
                    5'd0: fp_op = ALU_FCVT_W_D;
                    5'd1: fp_op = ALU_FCVT_WU_D;
                    5'd2: fp_op = ALU_FCVT_L_D;
                    5'd3: fp_op = ALU_FCVT_LU_D;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FCVT_S_X:
            begin
                unique case (f5)
                    5'd0: fp_op = ALU_FCVT_S_W;
                    5'd1: fp_op = ALU_FCVT_S_WU;
                    5'd2: fp_op = ALU_FCVT_S_L;
                    5'd3: fp_op = ALU_FCVT_S_LU;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FCVT_D_X:
            begin
                unique case (f5)
                    5'd0: fp_op = ALU_FCVT_D_W;
                    5'd1: fp_op = ALU_FCVT_D_WU;
                    5'd2: fp_op = ALU_FCVT_D_L;
                    5'd3: fp_op = ALU_FCVT_D_LU;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FSGNJ_S:
            begin
                unique case (f3)
                    3'd0: fp_op = ALU_FSGNJ_S;
                    3'd1: fp_op = ALU_FSGNJN_S;
                    3'd2: fp_op = ALU_FSGNJX_S;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FSGNJ_D:
            begin
                unique case (f3)
                    3'd0: fp_op = ALU_FSGNJ_D;
                    3'd1: fp_op = ALU_FSGNJN_D;
                    3'd2: fp_op = ALU_FSGNJX_D;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FMINMAX_S:
            begin
                unique case (f3)
                    3'd0: fp_op = ALU_FMIN_S;
                    3'd1: fp_op = ALU_FMAX_S;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FMINMAX_D:
            begin
                unique case (f3)
                    3'd0: fp_op = ALU_FMIN_D;
                    3'd1: fp_op = ALU_FMAX_D;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FCMP_S:
            begin
                unique case (f3)
                    3'd2: fp_op = ALU_FEQ_S;
                    3'd1: fp_op = ALU_FLT_S;
                    3'd0: fp_op = ALU_FLE_S;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FCMP_D:
            begin
                unique case (f3)
                    3'd2: fp_op = ALU_FEQ_D;
                    3'd1: fp_op = ALU_FLT_D;
                    3'd0: fp_op = ALU_FLE_D;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FMV_W_X: fp_op = ALU_FMV_W_X;
            F7_FMV_D_X: fp_op = ALU_FMV_D_X;
            F7_FMV_X_S:
            begin
                unique case (f3)
                    3'd0: fp_op = ALU_FMV_X_W;
                    3'd1: fp_op = ALU_FCLASS_S;
                    default: fp_op = ALU_NONE;
                endcase
            end
            F7_FMV_X_D:
            begin
                unique case (f3)
                    3'd0: fp_op = ALU_FMV_X_D;
                    3'd1: fp_op = ALU_FCLASS_D;
                    default: fp_op = ALU_NONE;
                endcase
            end
            default: fp_op = ALU_NONE;
        endcase
    end

    always_comb
    begin
        op = ALU_NONE;
        unique case (opc)
            OPC_OP:
            begin
                priority if (f7 == F7_MULDIV)
                    op = m_op;
                else if (f7 == F7_BASE)
                    op = rr_op;
                else if (f7 == F7_ALT && f3 == 3'd0)
                    op = ALU_SUB;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    op = ALU_SRA;
                else
                    op = ALU_NONE;
            end
            OPC_OP_IMM:
            begin
                priority if (f3 != 3'd5)
                    op = rr_op;
                else if (f7 == F7_BASE)
                    op = ALU_SRL;
                else if (f7 == F7_ALT)
                    op = ALU_SRA;
                else
                    op = ALU_NONE;
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    3'd0, 3'd1: op = ALU_SUB;
                    3'd4, 3'd5: op = ALU_SLT;
                    3'd6, 3'd7: op = ALU_SLTU;
                    default:    op = ALU_NONE;
                endcase
            end
            OPC_LOAD, OPC_STORE, OPC_JALR, OPC_JAL, OPC_LUI, OPC_AUIPC:
                op = ALU_ADD;
            OPC_OP_IMM_32:
            begin
                priority if (f3 == 3'd0)
                    op = ALU_ADDW;
                else if (f3 == 3'd1)
                    op = ALU_SLLW;
                else if (f3 == 3'd5 && f7 == F7_BASE)
                    op = ALU_SRLW;
                else if (f3 == 3'd5 && f7 == F7_ALT)
                    op = ALU_SRAW;
                else
                    op = ALU_NONE;
            end
            OPC_OP_32:
            begin
                unique case (f3)
                    3'd0:
                    begin
                        priority if (f7 == F7_BASE)
                            op = ALU_ADDW;
                        else if (f7 == F7_ALT)
                            op = ALU_SUBW;
                        else if (f7 == F7_MULDIV)
                            op = ALU_MULW;
                        else
                            op = ALU_NONE;
                    end
                    3'd1: op = ALU_SLLW;
                    3'd4: op = (f7 == F7_MULDIV) ? ALU_DIVW : ALU_NONE;
                    3'd5:
                    begin
                        priority if (f7 == F7_BASE)
                            op = ALU_SRLW;
                        else if (f7 == F7_ALT)
                            op = ALU_SRAW;
                        else if (f7 == F7_MULDIV)
                            op = ALU_DIVUW;
                        else
                            op = ALU_NONE;
                    end
                    3'd6: op = (f7 == F7_MULDIV) ? ALU_REMW : ALU_NONE;
                    3'd7: op = (f7 == F7_MULDIV) ? ALU_REMUW : ALU_NONE;
                    default: op = ALU_NONE;
                endcase
            end
            OPC_MADD:  op = ALU_FMADD_S;
            OPC_OP_FP: op = fp_op;
            OPC_LOAD_FP, OPC_STORE_FP:
                op = (f3 == 3'd2 || f3 == 3'd3) ? ALU_ADD : ALU_NONE;
            default: op = ALU_NONE;
        endcase
    end

    always_comb
    begin
        flags = '0;
        unique case (opc)
            OPC_OP, OPC_ALT_RTYPE, OPC_OP_FP:
            begin
                flags.reg_write = 1'b1;
                flags.alu_use   = 1'b1;
            end
            OPC_LOAD, OPC_LOAD_FP:
            begin
                flags.alu_src_imm = 1'b1;
                flags.mem_to_reg  = 1'b1;
                flags.reg_write   = 1'b1;
                flags.mem_read    = 1'b1;
            end
            OPC_STORE, OPC_STORE_FP:
            begin
                flags.alu_src_imm = 1'b1;
                flags.alu_use     = 1'b1;
                flags.mem_write   = 1'b1;
            end
            OPC_BRANCH:
            begin
                flags.alu_use = 1'b1;
                flags.branch  = 1'b1;
            end
            OPC_OP_IMM, OPC_LUI, OPC_AUIPC:
            begin
                flags.alu_src_imm = 1'b1;
                flags.reg_write   = 1'b1;
                flags.alu_use     = 1'b1;
            end
            OPC_JAL:
            begin
                flags.reg_write = 1'b1;
                flags.branch    = 1'b1;
            end
            OPC_JALR:
            begin
                flags.alu_src_imm = 1'b1;
                flags.reg_write   = 1'b1;
                flags.branch      = 1'b1;
            end
            default: flags = '0;
        endcase
    end

    assign result.op    = op;
    assign result.flags = flags;

endmodule

>>> hw/rtl/rv64_instruction_control_decoder_unit.sv
// Top level of the RV64 instruction control decoder with its request and result registers.
// An accepted request is held in the input register, then decoded into the result register, which offers it.
// Throughput: one request per cycle while out_ready does not stall the output; each register holds one.
// The decode table between the two registers is combinational.
// Reset clears both valid flags; the payload registers are not reset.
module rv64_instruction_control_decoder_unit
    import rv64_icd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [InstrWidth-1:0] instr_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [AluOpWidth-1:0] alu_operation,
    output logic                  reg_write_en,
    output logic                  alu_src_imm,
    output logic                  mem_to_reg_sel,
    output logic                  mem_read_en,
    output logic                  mem_write_en,
    output logic                  branch_flag,
    output logic                  alu_use_flag
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [InstrWidth-1:0] instr_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dec_result_t           result_reg;
    dec_result_t           dec_result;
    logic                  advance;

    rv64_icd_decode u_decode (
        .instr  (instr_reg),
        .result (dec_result)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            instr_reg <= instr_word;
        end
        if (advance && s1_valid_reg)
        begin
            result_reg <= dec_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign alu_operation  = result_reg.op;
    assign reg_write_en   = result_reg.flags.reg_write;
    assign alu_src_imm    = result_reg.flags.alu_src_imm;
    assign mem_to_reg_sel = result_reg.flags.mem_to_reg;
    assign mem_read_en    = result_reg.flags.mem_read;
    assign mem_write_en   = result_reg.flags.mem_write;
    assign branch_flag    = result_reg.flags.branch;
    assign alu_use_flag   = result_reg.flags.alu_use;

endmodule

>>> dv/rv64_instruction_control_decoder_unit_tb.sv
// Self-checking testbench for the RV64 instruction decoder: random and directed requests.
`timescale 1ns / 100ps

module rv64_instruction_control_decoder_unit_tb;
    import rv64_icd_pkg::*;

    localparam opcode_t OPC_MISC_MEM = 7'b0001111;
    localparam opcode_t OPC_SYSTEM   = 7'b1110011;
    localparam opcode_t OPC_UNUSED   = 7'b1111111;

    localparam funct7_t F7_FUSED_MADD  = 7'b1000011;
    localparam funct7_t F7_FUSED_MSUB  = 7'b1000111;
    localparam funct7_t F7_FUSED_NMADD = 7'b1001011;
    localparam funct7_t F7_FUSED_NMSUB = 7'b1001111;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;

    localparam logic [2:0] F3_FP_WORD   = 3'd2;
    localparam logic [2:0] F3_FP_DOUBLE = 3'd3;
    localparam logic [2:0] F3_FLE       = 3'd0;
    localparam logic [2:0] F3_FLT       = 3'd1;
    localparam logic [2:0] F3_FEQ       = 3'd2;
    localparam logic [2:0] F3_FMV       = 3'd0;
    localparam logic [2:0] F3_FCLASS    = 3'd1;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CALM_ITEMS   = 150;

    typedef struct packed {
        logic        drain;
        logic [31:0] word;
    } instr_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [InstrWidth-1:0] instr_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [AluOpWidth-1:0] alu_operation;
    logic                  reg_write_en;
    logic                  alu_src_imm;
    logic                  mem_to_reg_sel;
    logic                  mem_read_en;
    logic                  mem_write_en;
    logic                  branch_flag;
    logic                  alu_use_flag;

    instr_req_t  pending_q[$];
    dec_result_t expected_q[$];
    int          outstanding = 0;
    int          n_errors = 0;
    logic        calm = 1'b0;

    opcode_t opc_list [0:17] = '{OPC_OP, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_OP_IMM,
        OPC_OP_FP, OPC_OP_IMM_32, OPC_OP_32, OPC_JAL, OPC_JALR, OPC_LUI, OPC_AUIPC,
        OPC_LOAD_FP, OPC_STORE_FP, OPC_MADD, OPC_ALT_RTYPE, OPC_MISC_MEM, OPC_SYSTEM};

    funct7_t fp_f7_list [0:27] = '{F7_FADD_S, F7_FADD_D, F7_FSUB_S, F7_FSUB_D, F7_FMUL_S,
        F7_FMUL_D, F7_FDIV_S, F7_FDIV_D, F7_FSQRT_S, F7_FSQRT_D, F7_FCVT_X_S, F7_FCVT_X_D,
        F7_FCVT_S_X, F7_FCVT_D_X, F7_FSGNJ_S, F7_FSGNJ_D, F7_FMINMAX_S, F7_FMINMAX_D,
        F7_FCMP_S, F7_FCMP_D, F7_FMV_W_X, F7_FMV_D_X, F7_FMV_X_S, F7_FMV_X_D,
        F7_FUSED_MADD, F7_FUSED_MSUB, F7_FUSED_NMADD, F7_FUSED_NMSUB};

    funct7_t int_f7_list [0:2] = '{F7_BASE, F7_ALT, F7_MULDIV};

    rv64_instruction_control_decoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .instr_word    (instr_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .alu_operation (alu_operation),
        .reg_write_en  (reg_write_en),
        .alu_src_imm   (alu_src_imm),
        .mem_to_reg_sel(mem_to_reg_sel),
        .mem_read_en   (mem_read_en),
        .mem_write_en  (mem_write_en),
        .branch_flag   (branch_flag),
        .alu_use_flag  (alu_use_flag)
    );

    function automatic alu_op_t base_int_op(logic [2:0] f3);
        case (f3)
            F3_ADD:  return ALU_ADD;
            F3_SLL:  return ALU_SLL;
            F3_SLT:  return ALU_SLT;
            F3_SLTU: return ALU_SLTU;
            F3_XOR:  return ALU_XOR;
            F3_SR:   return ALU_SRL;
            F3_OR:   return ALU_OR;
            default: return ALU_AND;
        endcase
    endfunction

    function automatic alu_op_t muldiv_op(logic [2:0] f3);
        case (f3)
            F3_ADD:  return ALU_MUL;
            F3_SLL:  return ALU_MULH;
            F3_SLT:  return ALU_MULHSU;
            F3_SLTU: return ALU_MULHU;
            F3_XOR:  return ALU_DIV;
            F3_SR:   return ALU_DIVU;
            F3_OR:   return ALU_REM;
            default: return ALU_REMU;
        endcase
    endfunction

    function automatic alu_op_t fp_op(logic [2:0] f3, funct7_t f7, logic [4:0] f5);
        case (f7)
            F7_FADD_S:    return ALU_FADD_S;
            F7_FADD_D:    return ALU_FADD_D;
            F7_FSUB_S:    return ALU_FSUB_S;
            F7_FSUB_D:    return ALU_FSUB_D;
            F7_FMUL_S:    return ALU_FMUL_S;
            F7_FMUL_D:    return ALU_FMUL_D;
            F7_FDIV_S:    return ALU_FDIV_S;
            F7_FDIV_D:    return ALU_FDIV_D;
            F7_FSQRT_S:   return ALU_FSQRT_S;
            F7_FSQRT_D:   return ALU_FSQRT_D;
            F7_FCVT_X_S:  return f5 < 4 ? alu_op_t'(ALU_FCVT_W_S + f5) : ALU_NONE;
            F7_FCVT_X_D:  return f5 < 4 ? alu_op_t'(ALU_FCVT_W_D + f5) : ALU_NONE;
            F7_FCVT_S_X:  return f5 < 4 ? alu_op_t'(ALU_FCVT_S_W + f5) : ALU_NONE;
            F7_FCVT_D_X:  return f5 < 4 ? alu_op_t'(ALU_FCVT_D_W + f5) : ALU_NONE;
            F7_FSGNJ_S:   return f3 < 3 ? alu_op_t'(ALU_FSGNJ_S + f3) : ALU_NONE;
            F7_FSGNJ_D:   return f3 < 3 ? alu_op_t'(ALU_FSGNJ_D + f3) : ALU_NONE;
            F7_FMINMAX_S: return f3 < 2 ? alu_op_t'(ALU_FMIN_S + f3) : ALU_NONE;
            F7_FMINMAX_D: return f3 < 2 ? alu_op_t'(ALU_FMIN_D + f3) : ALU_NONE;
            F7_FCMP_S:
                return f3 == F3_FEQ ? ALU_FEQ_S : f3 == F3_FLT ? ALU_FLT_S :
                       f3 == F3_FLE ? ALU_FLE_S : ALU_NONE;
            F7_FCMP_D:
                return f3 == F3_FEQ ? ALU_FEQ_D : f3 == F3_FLT ? ALU_FLT_D :
                       f3 == F3_FLE ? ALU_FLE_D : ALU_NONE;
            F7_FMV_W_X:   return ALU_FMV_W_X;
            F7_FMV_D_X:   return ALU_FMV_D_X;
            F7_FMV_X_S:
                return f3 == F3_FMV ? ALU_FMV_X_W : f3 == F3_FCLASS ? ALU_FCLASS_S : ALU_NONE;
            F7_FMV_X_D:
                return f3 == F3_FMV ? ALU_FMV_X_D : f3 == F3_FCLASS ? ALU_FCLASS_D : ALU_NONE;
            // The fused encodings here always carry funct2 = 3, which selects nothing.
            default:      return ALU_NONE;
        endcase
    endfunction

    function automatic dec_result_t decode_instr(logic [31:0] w);
        opcode_t     opc;
        logic [2:0]  f3;
        funct7_t     f7;
        logic [4:0]  f5;
        dec_result_t res;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        f5  = w[24:20];
        res = '0;
        res.op = ALU_NONE;
        case (opc)
            OPC_OP, OPC_ALT_RTYPE, OPC_OP_FP: begin
                res.flags.reg_write = 1'b1;
                res.flags.alu_use   = 1'b1;
            end
            OPC_LOAD, OPC_LOAD_FP: begin
                res.flags.alu_src_imm = 1'b1;
                res.flags.mem_to_reg  = 1'b1;
                res.flags.reg_write   = 1'b1;
                res.flags.mem_read    = 1'b1;
            end
            OPC_STORE, OPC_STORE_FP: begin
                res.flags.alu_src_imm = 1'b1;
                res.flags.alu_use     = 1'b1;
                res.flags.mem_write   = 1'b1;
            end
            OPC_BRANCH: begin
                res.flags.alu_use = 1'b1;
                res.flags.branch  = 1'b1;
            end
            OPC_OP_IMM, OPC_LUI, OPC_AUIPC: begin
                res.flags.alu_src_imm = 1'b1;
                res.flags.reg_write   = 1'b1;
                res.flags.alu_use     = 1'b1;
            end
            OPC_JAL: begin
                res.flags.reg_write = 1'b1;
                res.flags.branch    = 1'b1;
            end
            OPC_JALR: begin
                res.flags.alu_src_imm = 1'b1;
                res.flags.reg_write   = 1'b1;
                res.flags.branch      = 1'b1;
            end
            default: ;
        endcase
        case (opc)
            OPC_OP: begin
                if (f7 == F7_MULDIV) res.op = muldiv_op(f3);
                else if (f7 == F7_BASE) res.op = base_int_op(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD) res.op = ALU_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR) res.op = ALU_SRA;
            end
            OPC_OP_IMM: begin
                if (f3 == F3_SR)
                    res.op = f7 == F7_BASE ? ALU_SRL : f7 == F7_ALT ? ALU_SRA : ALU_NONE;
                else
                    res.op = base_int_op(f3);
            end
            OPC_BRANCH: begin
                if (f3 == F3_BEQ || f3 == F3_BNE) res.op = ALU_SUB;
                else if (f3 == F3_BLT || f3 == F3_BGE) res.op = ALU_SLT;
                else if (f3 >= F3_OR) res.op = ALU_SLTU;
            end
            OPC_LOAD, OPC_STORE, OPC_JALR, OPC_JAL, OPC_LUI, OPC_AUIPC:
                res.op = ALU_ADD;
            OPC_OP_IMM_32: begin
                if (f3 == F3_ADD) res.op = ALU_ADDW;
                else if (f3 == F3_SLL) res.op = ALU_SLLW;
                else if (f3 == F3_SR)
                    res.op = f7 == F7_BASE ? ALU_SRLW : f7 == F7_ALT ? ALU_SRAW : ALU_NONE;
            end
            OPC_OP_32: begin
                case (f3)
                    F3_ADD:
                        res.op = f7 == F7_BASE ? ALU_ADDW : f7 == F7_ALT ? ALU_SUBW :
                                 f7 == F7_MULDIV ? ALU_MULW : ALU_NONE;
                    F3_SLL: res.op = ALU_SLLW;
                    F3_XOR: res.op = f7 == F7_MULDIV ? ALU_DIVW : ALU_NONE;
                    F3_SR:
                        res.op = f7 == F7_BASE ? ALU_SRLW : f7 == F7_ALT ? ALU_SRAW :
                                 f7 == F7_MULDIV ? ALU_DIVUW : ALU_NONE;
                    F3_OR:  res.op = f7 == F7_MULDIV ? ALU_REMW : ALU_NONE;
                    F3_AND: res.op = f7 == F7_MULDIV ? ALU_REMUW : ALU_NONE;
                    default: res.op = ALU_NONE;
                endcase
            end
            OPC_MADD:
                res.op = ALU_FMADD_S;
            OPC_OP_FP:
                res.op = fp_op(f3, f7, f5);
            OPC_LOAD_FP, OPC_STORE_FP:
                res.op = (f3 == F3_FP_WORD || f3 == F3_FP_DOUBLE) ? ALU_ADD : ALU_NONE;
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 99) < 88) begin
            w[6:0] = opc_list[$urandom_range(0, 17)];
            if ($urandom_range(0, 3) != 0) begin
                if (w[6:0] == OPC_OP_FP) begin
                    w[31:25] = fp_f7_list[$urandom_range(0, 27)];
                    if ($urandom_range(0, 1) != 0) w[24:20] = 5'($urandom_range(0, 5));
                    if ($urandom_range(0, 1) != 0) w[14:12] = 3'($urandom_range(0, 3));
                end else begin
                    w[31:25] = int_f7_list[$urandom_range(0, 2)];
                end
            end
        end
        return w;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 6;
            2:       return 20;
            default: return 45;
        endcase
    endfunction

    function automatic void queue_instr(logic [31:0] w, logic hold);
        instr_req_t req;
        req.drain = hold;
        req.word  = w;
        pending_q.push_back(req);
    endfunction

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin : driver
        logic took;
        int   in_gap;
        int   in_pct;
        int   in_cyc;
        if (!rst_n) begin
            in_valid   <= 1'b0;
            instr_word <= '0;
            calm       <= 1'b0;
            in_gap = 0;
            in_pct = 0;
            in_cyc = 0;
        end else begin
            took = in_valid && in_ready;
            if (took) void'(pending_q.pop_front());
            calm <= (pending_q.size() < CALM_ITEMS);
            if (in_cyc % 200 == 0) in_pct = pick_idle_pct();
            in_cyc++;
            if (in_valid && !took) begin
                in_valid <= 1'b1;
            end else if (in_gap != 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                in_valid <= 1'b0;
            end else if (pending_q[0].drain && (took || outstanding != 0)) begin
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < in_pct) begin
                in_gap = $urandom_range(0, 16);
                in_valid <= 1'b0;
            end else begin
                in_valid   <= 1'b1;
                instr_word <= pending_q[0].word;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : monitor
        dec_result_t want;
        int          out_stall;
        int          out_pct;
        int          out_cyc;
        if (!rst_n) begin
            out_ready   <= 1'b0;
            outstanding <= 0;
            out_stall = 0;
            out_pct   = 0;
            out_cyc   = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result offered with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (alu_operation !== want.op) begin
                        $error("alu_operation: expected %0d, got %0d", want.op, alu_operation);
                        n_errors++;
                    end
                    if (reg_write_en !== want.flags.reg_write) begin
                        $error("reg_write_en: expected %0b, got %0b",
                               want.flags.reg_write, reg_write_en);
                        n_errors++;
                    end
                    if (alu_src_imm !== want.flags.alu_src_imm) begin
                        $error("alu_src_imm: expected %0b, got %0b",
                               want.flags.alu_src_imm, alu_src_imm);
                        n_errors++;
                    end
                    if (mem_to_reg_sel !== want.flags.mem_to_reg) begin
                        $error("mem_to_reg_sel: expected %0b, got %0b",
                               want.flags.mem_to_reg, mem_to_reg_sel);
                        n_errors++;
                    end
                    if (mem_read_en !== want.flags.mem_read) begin
                        $error("mem_read_en: expected %0b, got %0b",
                               want.flags.mem_read, mem_read_en);
                        n_errors++;
                    end
                    if (mem_write_en !== want.flags.mem_write) begin
                        $error("mem_write_en: expected %0b, got %0b",
                               want.flags.mem_write, mem_write_en);
                        n_errors++;
                    end
                    if (branch_flag !== want.flags.branch) begin
                        $error("branch_flag: expected %0b, got %0b",
                               want.flags.branch, branch_flag);
                        n_errors++;
                    end
                    if (alu_use_flag !== want.flags.alu_use) begin
                        $error("alu_use_flag: expected %0b, got %0b",
                               want.flags.alu_use, alu_use_flag);
                        n_errors++;
                    end
                end
            end
            if (in_valid && in_ready) expected_q.push_back(decode_instr(instr_word));
            outstanding <= expected_q.size();
            if (out_cyc % 200 == 0) out_pct = pick_idle_pct();
            out_cyc++;
            if (out_stall != 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < out_pct) begin
                out_stall = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int k;
        queue_instr(32'h0000_0000, 1'b0);
        queue_instr(32'hFFFF_FFFF, 1'b0);
        queue_instr({F7_BASE, 10'h3A5, F3_ADD, 5'h0B, OPC_OP}, 1'b0);
        queue_instr({F7_ALT, 10'h0F1, F3_SR, 5'h1F, OPC_OP}, 1'b0);
        queue_instr({F7_ALT, 10'h2C3, F3_SLT, 5'h01, OPC_OP}, 1'b0);
        queue_instr({F7_MULDIV, 10'h155, F3_AND, 5'h0A, OPC_OP}, 1'b0);
        queue_instr({F7_ALT | F7_MULDIV, 10'h155, F3_SR, 5'h0A, OPC_OP_IMM}, 1'b0);
        queue_instr({7'h7F, 10'h2AA, F3_SLL, 5'h15, OPC_OP_IMM}, 1'b0);
        queue_instr({F7_ALT | F7_MULDIV, 10'h155, F3_SR, 5'h0A, OPC_OP_IMM_32}, 1'b0);
        queue_instr({F7_ALT, 10'h155, F3_SR, 5'h0A, OPC_OP_IMM_32}, 1'b0);
        queue_instr({F7_MULDIV, 10'h155, F3_SR, 5'h0A, OPC_OP_32}, 1'b0);
        queue_instr({F7_BASE, 10'h155, F3_SLT, 5'h0A, OPC_BRANCH}, 1'b0);
        queue_instr({F7_FCVT_X_S, 5'd4, 5'h0C, F3_ADD, 5'h0A, OPC_OP_FP}, 1'b1);
        queue_instr({F7_FCVT_X_S, 5'd3, 5'h0C, F3_ADD, 5'h0A, OPC_OP_FP}, 1'b0);
        queue_instr({F7_FUSED_MADD, 10'h155, F3_ADD, 5'h0A, OPC_OP_FP}, 1'b0);
        queue_instr({25'h1FF_FFFF, OPC_MADD}, 1'b0);
        queue_instr({25'h0A5_5A5A, OPC_MISC_MEM}, 1'b0);
        queue_instr({25'h000_0000, OPC_SYSTEM}, 1'b0);
        queue_instr({F7_BASE, 10'h155, F3_ADD, 5'h0A, OPC_ALT_RTYPE}, 1'b0);
        queue_instr({F7_FCMP_D, 10'h155, F3_FEQ, 5'h0A, OPC_OP_FP}, 1'b0);
        queue_instr({F7_FMV_X_S, 10'h155, F3_FCLASS, 5'h0A, OPC_OP_FP}, 1'b0);
        queue_instr({F7_BASE, 10'h155, F3_SLL, 5'h0A, OPC_LOAD_FP}, 1'b0);
        queue_instr({F7_ALT, 10'h155, F3_SLTU, 5'h0A, OPC_STORE_FP}, 1'b0);
        queue_instr({F7_ALT, 10'h3FF, F3_AND, 5'h1F, OPC_JALR}, 1'b0);
        queue_instr({25'h155_5555, OPC_UNUSED}, 1'b0);
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_instr(random_instr(), k == 500 || k == 1000);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        do @(negedge clk); while (pending_q.size() != 0 || expected_q.size() != 0);
        repeat (20) @(negedge clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rv64_icd_pkg.sv
hw/rtl/rv64_icd_decode.sv
hw/rtl/rv64_instruction_control_decoder_unit.sv
dv/rv64_instruction_control_decoder_unit_tb.sv
